### hw/rtl/deq_pkg.sv
// shared types and constants for the double-ended queue core
// no dependencies; imported by every module of the block
package deq_pkg;

  // default sizing
  localparam int DEQ_DEPTH      = 256;
  localparam int DEQ_DATA_WIDTH = 32;

  // members per registered group of the tail gather tree
  localparam int GATHER_GROUP = 16;

  // port field widths
  localparam int OP_W    = 3;
  localparam int VALUE_W = 32;
  localparam int KEEP_W  = 9;
  localparam int COUNT_W = 9;
  localparam int STAT_W  = 2;

  // operation codes
  typedef enum logic [OP_W-1:0] {
    OP_PUSH_FRONT = 3'd0,
    OP_PUSH_BACK  = 3'd1,
    OP_POP_FRONT  = 3'd2,
    OP_POP_BACK   = 3'd3,
    OP_TRUNCATE   = 3'd4
  } deq_op_t;

  // result status codes
  typedef enum logic [STAT_W-1:0] {
    ST_OK    = 2'd0,
    ST_EMPTY = 2'd1,
    ST_FULL  = 2'd2
  } deq_status_t;

  // sequencer states
  typedef enum logic [1:0] {
    S_IDLE,
    S_GATHER,
    S_FINISH
  } deq_state_t;

  // command broadcast to every cell
  typedef struct packed {
    logic              en;
    deq_op_t           op;
    logic [KEEP_W-1:0] keep;
  } deq_cmd_t;

endpackage

### hw/rtl/deq_cell.sv
// one storage cell of the queue chain: an entry, its valid bit and a tail pick mark
// depends on deq_pkg; neighbors are the cells at index-1 and index+1
module deq_cell
  import deq_pkg::*;
#(
  parameter int INDEX      = 0,
  parameter int DATA_WIDTH = DEQ_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic                  rst,
  input  deq_cmd_t              cmd,
  input  logic [DATA_WIDTH-1:0] push_data,
  input  logic [DATA_WIDTH-1:0] left_data,
  input  logic                  left_valid,
  input  logic [DATA_WIDTH-1:0] right_data,
  input  logic                  right_valid,
  output logic [DATA_WIDTH-1:0] data,
  output logic                  valid,
  output logic                  pick
);

  logic [DATA_WIDTH-1:0] data_next;
  logic                  valid_next;
  logic                  pick_next;

  // local update from the broadcast command and the two neighbors
  always_comb begin
    data_next  = data;
    valid_next = valid;
    pick_next  = pick;
    if (cmd.en) begin
      pick_next = 1'b0;
      case (cmd.op)
        OP_PUSH_FRONT: begin
          data_next  = left_data;
          valid_next = left_valid;
        end
        OP_PUSH_BACK: begin
          // first free cell after the occupied run takes the value
          if (left_valid && !valid) begin
            data_next  = push_data;
            valid_next = 1'b1;
          end
        end
        OP_POP_FRONT: begin
          data_next  = right_data;
          valid_next = right_valid;
        end
        OP_POP_BACK: begin
          // last occupied cell frees itself and marks its entry for the gather
          if (valid && !right_valid) begin
            valid_next = 1'b0;
            pick_next  = 1'b1;
          end
        end
        OP_TRUNCATE: begin
          if (int'(cmd.keep) <= INDEX) begin
            valid_next = 1'b0;
          end
        end
        default: begin
        end
      endcase
    end
  end

  // control bits
  always_ff @(posedge clk) begin
    if (rst) begin
      valid <= 1'b0;
      pick  <= 1'b0;
    end else begin
      valid <= valid_next;
      pick  <= pick_next;
    end
  end

  // entry payload
  always_ff @(posedge clk) begin
    data <= data_next;
  end

endmodule

### hw/rtl/deq_gather.sv
// registered or-tree that pulls the marked tail entry out of the cell row
// depends on deq_pkg; one level of group registers, then a final or
module deq_gather
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEQ_DEPTH,
  parameter int DATA_WIDTH = DEQ_DATA_WIDTH
) (
  input  logic                  clk,
  input  logic [DATA_WIDTH-1:0] cell_data [DEPTH],
  input  logic                  cell_pick [DEPTH],
  output logic [DATA_WIDTH-1:0] picked
);

  localparam int NGROUPS = (DEPTH + GATHER_GROUP - 1) / GATHER_GROUP;

  logic [DATA_WIDTH-1:0] group_or      [NGROUPS];
  logic [DATA_WIDTH-1:0] group_or_next [NGROUPS];

  // masked or within each group; at most one cell is marked
  always_comb begin
    for (int g = 0; g < NGROUPS; g++) begin
      group_or_next[g] = '0;
      for (int k = 0; k < GATHER_GROUP; k++) begin
        if (g * GATHER_GROUP + k < DEPTH) begin
          if (cell_pick[g * GATHER_GROUP + k]) begin
            group_or_next[g] = group_or_next[g] | cell_data[g * GATHER_GROUP + k];
          end
        end
      end
    end
  end

  // group registers
  always_ff @(posedge clk) begin
    for (int g = 0; g < NGROUPS; g++) begin
      group_or[g] <= group_or_next[g];
    end
  end

  // final or over the groups
  always_comb begin
    picked = '0;
    for (int g = 0; g < NGROUPS; g++) begin
      picked = picked | group_or[g];
    end
  end

endmodule

### hw/rtl/double_ended_queue_core.sv
// top level of the double-ended queue: cell chain, tail gather, count and result register
// depends on deq_pkg, deq_cell and deq_gather
//
//  channel | dir | tdata (low bit up)                   | tuser (low bit up)
//  s_*     | in  | push_value[31:0], keep_length[40:32]  | opcode[2:0]
//  m_*     | out | popped_value[31:0], entry_count[40:32]| status[1:0], is_empty[2]
//
// push front/back, pop front, truncate and rejected operations: the result is
// registered and shown the cycle after the transfer.
// pop back from a non-empty queue: the tail cell marks its entry, the registered gather
// tree pulls it out of the chain, then the finish state loads it once the slot is free.
// a new item is taken only while the sequencer is idle and the result slot is free
// or being taken; rst clears valid bits, count, sequencer and result valid.
module double_ended_queue_core
  import deq_pkg::*;
#(
  parameter int DEPTH      = DEQ_DEPTH,
  parameter int DATA_WIDTH = DEQ_DATA_WIDTH
) (
  input  logic        clk,
  input  logic        rst,
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [47:0] s_tdata,  // push_value[31:0], keep_length[40:32], zero pad
  input  logic [2:0]  s_tuser,  // opcode[2:0]
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [47:0] m_tdata,  // popped_value[31:0], entry_count[40:32], zero pad
  output logic [2:0]  m_tuser   // status[1:0], is_empty[2]
);

  localparam int CW = $clog2(DEPTH + 1);
  localparam int KW = (CW > KEEP_W) ? CW : KEEP_W;

  // input fields
  deq_op_t            in_op;
  logic [VALUE_W-1:0] in_value;
  logic [KEEP_W-1:0]  in_keep;
  logic [63:0]        in_value_wide;
  logic [DATA_WIDTH-1:0] push_data;

  assign in_op         = deq_op_t'(s_tuser[2:0]);
  assign in_value      = s_tdata[31:0];
  assign in_keep       = s_tdata[40:32];
  assign in_value_wide = 64'(in_value);
  assign push_data     = in_value_wide[DATA_WIDTH-1:0];

  // cell row
  logic [DATA_WIDTH-1:0] cell_data  [DEPTH];
  logic                  cell_valid [DEPTH];
  logic                  cell_pick  [DEPTH];
  deq_cmd_t              cmd;

  // state and handshake
  deq_state_t  state, state_next;
  logic [CW-1:0] count, count_next;
  logic        accept;
  logic        out_free;
  logic        is_full;
  logic        is_empty_now;
  logic        rejected;
  logic        load_direct;
  logic        load_gather;

  // result register
  logic        res_valid;
  deq_status_t res_status;
  logic [VALUE_W-1:0] res_popped;
  logic [CW-1:0] res_count;

  deq_status_t dir_status;
  logic [VALUE_W-1:0] dir_popped;
  logic [DATA_WIDTH-1:0] picked;
  logic signed [63:0] front_wide;
  logic signed [63:0] picked_wide;
  logic [KW-1:0] keep_ext;
  logic [KW-1:0] count_ext;

  assign out_free     = !res_valid || m_tready;
  assign accept       = s_tvalid && s_tready;
  assign is_full      = cell_valid[DEPTH-1];
  assign is_empty_now = !cell_valid[0];
  assign keep_ext     = KW'(in_keep);
  assign count_ext    = KW'(count);

  // operations that fail leave the state untouched
  always_comb begin
    unique case (in_op)
      OP_PUSH_FRONT, OP_PUSH_BACK: rejected = is_full;
      OP_POP_FRONT, OP_POP_BACK:   rejected = is_empty_now;
      default:                     rejected = 1'b0;
    endcase
  end

  assign cmd.en   = accept && !rejected;
  assign cmd.op   = in_op;
  assign cmd.keep = in_keep;

  // chain of cells, each wired to its neighbors
  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    logic [DATA_WIDTH-1:0] l_data;
    logic                  l_valid;
    logic [DATA_WIDTH-1:0] r_data;
    logic                  r_valid;
    if (i == 0) begin : g_head
      assign l_data  = push_data;
      assign l_valid = 1'b1;
    end else begin : g_mid_l
      assign l_data  = cell_data[i-1];
      assign l_valid = cell_valid[i-1];
    end
    if (i == DEPTH - 1) begin : g_tail
      assign r_data  = '0;
      assign r_valid = 1'b0;
    end else begin : g_mid_r
      assign r_data  = cell_data[i+1];
      assign r_valid = cell_valid[i+1];
    end
    deq_cell #(
      .INDEX      (i),
      .DATA_WIDTH (DATA_WIDTH)
    ) u_cell (
      .clk         (clk),
      .rst         (rst),
      .cmd         (cmd),
      .push_data   (push_data),
      .left_data   (l_data),
      .left_valid  (l_valid),
      .right_data  (r_data),
      .right_valid (r_valid),
      .data        (cell_data[i]),
      .valid       (cell_valid[i]),
      .pick        (cell_pick[i])
    );
  end

  // tail entry gather for pop back
  deq_gather #(
    .DEPTH      (DEPTH),
    .DATA_WIDTH (DATA_WIDTH)
  ) u_gather (
    .clk       (clk),
    .cell_data (cell_data),
    .cell_pick (cell_pick),
    .picked    (picked)
  );

  assign front_wide  = 64'($signed(cell_data[0]));
  assign picked_wide = 64'($signed(picked));

  // count update and direct result fields
  always_comb begin
    count_next = count;
    dir_status = ST_OK;
    dir_popped = '0;
    case (in_op)
      OP_PUSH_FRONT, OP_PUSH_BACK: begin
        if (is_full) begin
          dir_status = ST_FULL;
        end else begin
          count_next = count + CW'(1);
        end
      end
      OP_POP_FRONT: begin
        if (is_empty_now) begin
          dir_status = ST_EMPTY;
        end else begin
          count_next = count - CW'(1);
          dir_popped = front_wide[VALUE_W-1:0];
        end
      end
      OP_POP_BACK: begin
        if (is_empty_now) begin
          dir_status = ST_EMPTY;
        end else begin
          count_next = count - CW'(1);
        end
      end
      OP_TRUNCATE: begin
        if (keep_ext < count_ext) begin
          count_next = CW'(keep_ext);
        end
      end
      default: begin
      end
    endcase
  end

  // sequencer next state
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (accept && !rejected && in_op == OP_POP_BACK) begin
          state_next = S_GATHER;
        end
      end
      S_GATHER: state_next = S_FINISH;
      S_FINISH: begin
        if (out_free) begin
          state_next = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  // sequencer outputs
  always_comb begin
    s_tready    = 1'b0;
    load_direct = 1'b0;
    load_gather = 1'b0;
    unique case (state)
      S_IDLE: begin
        s_tready    = out_free;
        load_direct = accept && !(!rejected && in_op == OP_POP_BACK);
      end
      S_GATHER: begin
      end
      S_FINISH: load_gather = out_free;
      default: begin
      end
    endcase
  end

  // control registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      count     <= '0;
      res_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (accept) begin
        count <= count_next;
      end
      if (load_direct || load_gather) begin
        res_valid <= 1'b1;
      end else if (m_tready) begin
        res_valid <= 1'b0;
      end
    end
  end

  // result payload
  always_ff @(posedge clk) begin
    if (load_direct) begin
      res_status <= dir_status;
      res_popped <= dir_popped;
      res_count  <= count_next;
    end else if (load_gather) begin
      res_status <= ST_OK;
      res_popped <= picked_wide[VALUE_W-1:0];
      res_count  <= count;
    end
  end

  // output packing
  assign m_tvalid = res_valid;
  assign m_tdata  = {7'd0, COUNT_W'(res_count), res_popped};
  assign m_tuser  = {(res_count == '0), res_status};

endmodule
